/* design/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TBG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone burst check failed");

// Next-cycle implication, disabled during reset.
`define TBG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone burst check failed");

`endif

/* design/tbg_pkg.sv */
`timescale 1ns / 1ps
package tbg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TBL_SIZE        = 1 << SINE_TABLE_BITS;

  localparam int FREQ_W = 15;
  localparam int DUR_W  = 16;
  localparam int RATE_W = 18;
  localparam int LEN_W  = 24;
  localparam int CYC_W  = 22;
  localparam int NUM_W  = 32;
  localparam int PROD_W = 40;
  localparam int MAG_W  = 15;
  localparam int SMP_W  = 16;
  localparam int DEN_W  = 48;
  localparam int MA_W   = 48;
  localparam int MB_W   = 24;
  localparam int MRES_W = 64;
  localparam int DIV_W  = (PROD_W + PHASE_BITS > MRES_W) ? PROD_W + PHASE_BITS : MRES_W;

  localparam logic [LEN_W-1:0]  LEN_MAX    = '1;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
  localparam longint unsigned   PI_Q30     = 64'd3373259426;

  // Milliseconds to whole cycles: floor(2^33 / 1000) gives an estimate that is
  // at most one short for any numerator below 2^31
  localparam int               MS_PER_S    = 1000;
  localparam int               MS_ROUND    = 500;
  localparam int               RECIP_SHIFT = 33;
  localparam logic [MB_W-1:0]  RECIP_MS    = MB_W'(8589934);

  typedef struct packed {
    logic              cmd;
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUR_W-1:0]  duration_ms;
  } item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last_sample;
    logic                    playing;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MFD, OP_CYC, OP_REC, OP_QC, OP_MPR, OP_LEN, OP_FADE,
    OP_INC, OP_ACC, OP_FIN, OP_LOOK, OP_MGG, OP_MFF, OP_MNUM, OP_DMAG, OP_QMAG,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic active;
    logic faded;
    logic room;
  } dp_status_t;

  typedef logic [MAG_W-1:0] rom_t [TBL_SIZE];

  // Quarter-wave table: Taylor series in Q30, sampled at bin centers.
  function automatic rom_t build_rom();
    rom_t             rom;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint unsigned  v;
    longint           sum;
    int unsigned      i;
    int unsigned      k;
    for (i = 0; i < TBL_SIZE; i++) begin
      x = (PI_Q30 * 64'(2 * i + 1)) >> (SINE_TABLE_BITS + 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (k = 1; k < 9; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      rom[i] = MAG_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic [LEN_W-1:0] sat_len(input logic [DIV_W-1:0] v);
    return (v > DIV_W'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
  endfunction

endpackage

/* design/tone_burst_generator.sv */
`timescale 1ns / 1ps
// Sine tone burst generator with a squared linear fade. A start item (cmd 1) sets up
// a burst from its frequency and duration and gives no result; each tick item
// (cmd 0) gives one Q15 sample, zero with playing low when no burst is running.
// One item is taken at a time. Rounding the duration to whole cycles uses a
// reciprocal multiply; every other division runs on one bit-per-cycle divider of
// 72 steps. A start runs four of its steps on the divider; a tick inside a fade
// ramp runs one, a tick without fade none. A tick waits until the output register
// is free. A finished result waits in the output register while the next item is
// taken. sample_rate is written through the cfg channel, which is always ready,
// and must only change while idle.
module tone_burst_generator import tbg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RATE_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign item_stall = !cmd.capture;
  assign cfg_ready  = 1'b1;

  tbg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_start (item.cmd),
    .status     (status),
    .cmd        (cmd)
  );

  tbg_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

/* design/tbg_div.sv */
`timescale 1ns / 1ps
module tbg_div import tbg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // Shift in one dividend bit and try a subtract
  assign rem_sh = {rem, quot[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
      quot <= dividend;
      den  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quot <= {quot[DIV_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

endmodule

/* design/tbg_datapath.sv */
`timescale 1ns / 1ps
module tbg_datapath import tbg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  item_t             item,
  input  logic              cfg_valid,
  input  logic [RATE_W-1:0] cfg_data,
  output result_t           result,
  output logic              result_valid,
  input  logic              result_stall
);

  logic [RATE_W-1:0]     sample_rate;
  item_t                 item_q;
  logic [FREQ_W-1:0]     freq;
  logic [RATE_W-1:0]     fs;
  logic [MRES_W-1:0]     mres;
  logic [PROD_W-1:0]     prod;
  logic [DEN_W-1:0]      den_r;
  logic [DEN_W-1:0]      gg;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_inc;
  logic [LEN_W-1:0]      sample_index;
  logic [LEN_W-1:0]      burst_length;
  logic [LEN_W-1:0]      fade_length;
  logic                  tone_busy;
  logic [MAG_W-1:0]      mag;
  logic                  neg;
  logic                  act;
  logic                  faded;
  logic [LEN_W-1:0]      gain;
  logic [NUM_W-1:0]      cyc_num;
  logic [CYC_W-1:0]      cyc;
  logic [CYC_W-1:0]      cyc_est;
  logic [NUM_W-1:0]      cyc_back;

  logic [MA_W-1:0]       mul_a;
  logic [MB_W-1:0]       mul_b;
  logic                  mul_en;
  logic [MA_W+MB_W-1:0]  mul_p;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dvd;
  logic [DEN_W-1:0]      div_den;
  logic                  div_busy;
  logic [DIV_W-1:0]      div_q;
  logic [DEN_W-1:0]      div_r;
  logic [DEN_W-1:0]      u_den_q;
  logic [PHASE_BITS-1:0] frac;

  logic [SINE_TABLE_BITS+1:0] top;
  logic [SINE_TABLE_BITS-1:0] ridx;
  logic [LEN_W:0]             k1;
  logic [LEN_W-1:0]           rlen;
  logic                       fade_in;
  logic                       tail_fade;
  logic                       room;
  logic [SMP_W-1:0]           smag;
  logic [LEN_W:0]             idx_inc;

  tbg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  // Pick multiplier operands for the current step
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MFD:  begin mul_a = MA_W'(freq);                mul_b = MB_W'(item_q.duration_ms); end
      OP_REC:  begin mul_a = MA_W'(cyc_num);             mul_b = RECIP_MS; end
      OP_MPR:  begin mul_a = MA_W'(cyc);                 mul_b = MB_W'(fs); end
      OP_INC:  begin mul_a = MA_W'(freq);                mul_b = MB_W'(burst_length - 1'b1); end
      OP_MGG:  begin mul_a = MA_W'(gain);                mul_b = MB_W'(gain); end
      OP_MFF:  begin mul_a = MA_W'(fade_length);         mul_b = MB_W'(fade_length); end
      OP_MNUM: begin mul_a = MA_W'(gg);                  mul_b = MB_W'(mag); end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Pick divider operands for the current step
  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_LEN: begin
        div_dvd = DIV_W'(mres) + DIV_W'(freq) - DIV_W'(1);
        div_den = DEN_W'(freq);
      end
      OP_FADE: begin
        div_dvd = DIV_W'({prod, 1'b0}) + DIV_W'(freq) * DIV_W'(10);
        div_den = DEN_W'(freq) * DEN_W'(20);
      end
      OP_INC: begin
        div_dvd = DIV_W'(freq) << PHASE_BITS;
        div_den = DEN_W'(fs);
      end
      OP_ACC: begin
        div_dvd = DIV_W'(prod - mres[PROD_W-1:0]) << PHASE_BITS;
        div_den = DEN_W'({fs, 1'b0});
      end
      OP_DMAG: begin
        div_dvd = DIV_W'(mres) + DIV_W'(den_r >> 1);
        div_den = den_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  // Fraction of a turn, rounded half up
  assign frac = div_q[PHASE_BITS-1:0] +
                PHASE_BITS'({div_r, 1'b0} >= {1'b0, u_den_q});

  // Keep the divisor of the running division for rounding
  always_ff @(posedge clk) begin
    if (div_start) u_den_q <= div_den;
  end

  // Whole cycles: reciprocal estimate, then one compare against 1000 * estimate
  assign cyc_est  = mres[RECIP_SHIFT +: CYC_W];
  assign cyc_back = NUM_W'({cyc_est, 10'b0}) - NUM_W'({cyc_est, 4'b0}) -
                    NUM_W'({cyc_est, 3'b0});

  // Table address and fade gain
  assign top       = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
  assign ridx      = top[SINE_TABLE_BITS] ? ~top[SINE_TABLE_BITS-1:0]
                                          : top[SINE_TABLE_BITS-1:0];
  assign k1        = {1'b0, sample_index} + 1'b1;
  assign rlen      = burst_length - sample_index;
  assign fade_in   = (fade_length != '0) && (k1 < {1'b0, fade_length});
  assign tail_fade = (fade_length != '0) && (rlen < fade_length);
  assign gain      = fade_in ? k1[LEN_W-1:0] : rlen;
  assign room      = !result_valid || !result_stall;
  assign smag      = {1'b0, mag};
  assign idx_inc   = {1'b0, sample_index} + 1'b1;

  assign status = '{div_busy: div_busy, active: act, faded: faded, room: room};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= RATE_RESET;
      phase_acc    <= '0;
      phase_inc    <= '0;
      sample_index <= '0;
      burst_length <= '0;
      fade_length  <= '0;
      tone_busy    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) sample_rate <= cfg_data;
      if (cmd.capture) item_q <= item;
      if (mul_en) mres <= mul_p[MRES_W-1:0];
      // Raise valid on a new result, drop it once it transfers
      if (cmd.op == OP_PUSH && room) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          freq <= (item_q.frequency_hz == '0) ? FREQ_W'(1) : item_q.frequency_hz;
          fs   <= (sample_rate == '0) ? RATE_W'(1) : sample_rate;
        end
        OP_CYC:  cyc_num <= mres[NUM_W-1:0] + NUM_W'(MS_ROUND);
        OP_QC:   cyc <= (cyc_num - cyc_back >= NUM_W'(MS_PER_S)) ? cyc_est + 1'b1 : cyc_est;
        OP_LEN:  prod <= mres[PROD_W-1:0];
        OP_FADE: burst_length <= sat_len(div_q);
        OP_INC:  fade_length <= sat_len(div_q);
        OP_ACC:  phase_inc <= frac;
        OP_FIN: begin
          phase_acc    <= (burst_length != '0) ? frac : '0;
          sample_index <= '0;
          tone_busy    <= burst_length != '0;
        end
        OP_LOOK: begin
          mag   <= SINE_ROM[ridx];
          neg   <= top[SINE_TABLE_BITS+1];
          act   <= tone_busy && (sample_index < burst_length);
          faded <= fade_in || tail_fade;
        end
        OP_MFF:  gg <= mres[DEN_W-1:0];
        OP_MNUM: den_r <= mres[DEN_W-1:0];
        OP_QMAG: mag <= div_q[MAG_W-1:0];
        OP_PUSH: begin
          if (room) begin
            result.sample      <= act ? (neg ? -smag : smag) : '0;
            result.last_sample <= act && (idx_inc == {1'b0, burst_length});
            result.playing     <= act;
            // Advance the burst
            if (act) begin
              sample_index <= idx_inc[LEN_W-1:0];
              phase_acc    <= phase_acc + phase_inc;
              tone_busy    <= idx_inc < {1'b0, burst_length};
            end else begin
              tone_busy <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/tbg_ctrl.sv */
`timescale 1ns / 1ps
module tbg_ctrl import tbg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_start,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_MFD, S_CYC, S_REC, S_QC, S_MPR, S_LEN, S_FADE, S_INC, S_ACC,
    S_FIN, S_WAIT, T_LOOK, T_SEL, T_GG, T_FF, T_NUM, T_DIV, T_Q, T_OUT
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;

  function automatic dp_op_t op_of(input state_t s);
    case (s)
      S_LOAD:  return OP_LOAD;
      S_MFD:   return OP_MFD;
      S_CYC:   return OP_CYC;
      S_REC:   return OP_REC;
      S_QC:    return OP_QC;
      S_MPR:   return OP_MPR;
      S_LEN:   return OP_LEN;
      S_FADE:  return OP_FADE;
      S_INC:   return OP_INC;
      S_ACC:   return OP_ACC;
      S_FIN:   return OP_FIN;
      T_LOOK:  return OP_LOOK;
      T_GG:    return OP_MGG;
      T_FF:    return OP_MFF;
      T_NUM:   return OP_MNUM;
      T_DIV:   return OP_DMAG;
      T_Q:     return OP_QMAG;
      T_OUT:   return OP_PUSH;
      default: return OP_NONE;
    endcase
  endfunction

  // Step through the start and tick sequences
  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      S_IDLE:  if (item_valid) state_next = item_start ? S_LOAD : T_LOOK;
      S_LOAD:  state_next = S_MFD;
      S_MFD:   state_next = S_CYC;
      S_CYC:   state_next = S_REC;
      S_REC:   state_next = S_QC;
      S_QC:    state_next = S_MPR;
      S_MPR:   state_next = S_LEN;
      S_LEN:   begin state_next = S_WAIT; ret_next = S_FADE; end
      S_FADE:  begin state_next = S_WAIT; ret_next = S_INC; end
      S_INC:   begin state_next = S_WAIT; ret_next = S_ACC; end
      S_ACC:   begin state_next = S_WAIT; ret_next = S_FIN; end
      S_FIN:   state_next = S_IDLE;
      S_WAIT:  if (!status.div_busy) state_next = ret;
      T_LOOK:  state_next = T_SEL;
      T_SEL:   state_next = (status.active && status.faded) ? T_GG : T_OUT;
      T_GG:    state_next = T_FF;
      T_FF:    state_next = T_NUM;
      T_NUM:   state_next = T_DIV;
      T_DIV:   begin state_next = S_WAIT; ret_next = T_Q; end
      T_Q:     state_next = T_OUT;
      T_OUT:   if (status.room) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the registered command
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= S_IDLE;
      cmd.op      <= OP_NONE;
      cmd.capture <= 1'b1;
    end else begin
      state       <= state_next;
      ret         <= ret_next;
      cmd.op      <= op_of(state_next);
      cmd.capture <= state_next == S_IDLE;
    end
  end

endmodule

/* design/tbg_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbg_checker import tbg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input item_t             item,
  input logic              result_valid,
  input logic              result_stall,
  input result_t           result,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [RATE_W-1:0] cfg_data
);

  // Hold a stalled result
  `TBG_ASSERT_NXT(a_res_hold, clk, rst, result_valid && result_stall, result_valid)
  `TBG_ASSERT_NXT(a_res_stable, clk, rst, result_valid && result_stall, $stable(result))
  // One item in work at a time
  `TBG_ASSERT_NXT(a_one_item, clk, rst, item_valid && !item_stall, item_stall)
  // Final sample belongs to a burst
  `TBG_ASSERT_IMP(a_last_play, clk, rst, result_valid && result.last_sample, result.playing)
  // Silence when no burst runs
  `TBG_ASSERT_IMP(a_idle_zero, clk, rst, result_valid && !result.playing, result.sample == '0)

endmodule

bind tone_burst_generator tbg_checker u_chk (.*);
